[rtl/npq_pkg.sv]
`timescale 1ns / 1ps
// Package of the palette quantizer: shared constants, the beat that travels
// down the cell chain, and the 5-bit to 8-bit channel expansion table.
// No dependencies.
package npq_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned CntW       = 9;
  localparam int unsigned SqW        = 2 * ChanW;
  localparam int unsigned DistW      = SqW + 2;

  localparam logic FuncWrite   = 1'b0;
  localparam logic FuncConvert = 1'b1;

  // c5 * 255 / 31, rounded down.
  localparam logic [ChanW-1:0] ExpandLut [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic             vld;
    logic             func;
    logic [IdxW-1:0]  idx;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             opaque;
    logic [DistW-1:0] best_dist;
    logic [IdxW-1:0]  best_idx;
  } beat_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             opaque;
  } entry_t;

endpackage

[rtl/npq_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the palette quantizer: valid/ready plus one palette write
// or pixel beat. Depends on npq_pkg.
interface npq_in_if
  import npq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [IdxW-1:0]  entry_index;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [ChanW-1:0] alpha;

  modport source (output valid, func, entry_index, red, green, blue, alpha, input ready);
  modport sink   (input valid, func, entry_index, red, green, blue, alpha, output ready);
endinterface

[rtl/npq_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the palette quantizer: valid/ready plus the palette index.
// Depends on npq_pkg.
interface npq_out_if
  import npq_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

[rtl/npq_cell.sv]
`timescale 1ns / 1ps
// One cell of the quantizer chain: holds one palette entry and, over two
// registered steps, folds its distance into the passing pixel beat.
// Depends on npq_pkg.
module npq_cell
  import npq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [IdxW-1:0] cell_idx_i,
  input  logic [CntW-1:0] count_i,
  input  logic            skip_first_i,
  input  beat_t           beat_i,
  output beat_t           beat_o
);

  entry_t           entry_q, entry_d;
  beat_t            mid_q, out_q;
  logic             mid_vld_q, out_vld_q;
  logic [SqW-1:0]   sq_q [3];
  logic [SqW-1:0]   sq_d [3];
  logic             elig_q, elig_d;
  logic [ChanW-1:0] diff [3];
  logic [ChanW-1:0] pix  [3];
  logic [ChanW-1:0] ent  [3];
  logic [DistW-1:0] cell_dist;
  beat_t            out_d;

  // A write beat lands in the entry as it enters; earlier pixels are already
  // further down the chain, later ones see the new value.
  always_comb begin
    entry_d = entry_q;
    if (beat_i.vld && beat_i.func == FuncWrite && beat_i.idx == cell_idx_i) begin
      entry_d.red    = beat_i.red;
      entry_d.green  = beat_i.green;
      entry_d.blue   = beat_i.blue;
      entry_d.opaque = beat_i.opaque;
    end
  end

  assign pix[0] = beat_i.red;
  assign pix[1] = beat_i.green;
  assign pix[2] = beat_i.blue;
  assign ent[0] = entry_q.red;
  assign ent[1] = entry_q.green;
  assign ent[2] = entry_q.blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (pix[c] > ent[c]) ? (pix[c] - ent[c]) : (ent[c] - pix[c]);
      sq_d[c] = SqW'(diff[c]) * SqW'(diff[c]);
    end
    elig_d = entry_q.opaque && ({1'b0, cell_idx_i} < count_i)
             && !(skip_first_i && cell_idx_i == '0);
  end

  assign cell_dist = DistW'(sq_q[0]) + DistW'(sq_q[1]) + DistW'(sq_q[2]);

  always_comb begin
    out_d = mid_q;
    if (mid_q.func == FuncConvert && elig_q && cell_dist < mid_q.best_dist) begin
      out_d.best_dist = cell_dist;
      out_d.best_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      mid_vld_q <= beat_i.vld;
      out_vld_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      mid_q   <= beat_i;
      sq_q    <= sq_d;
      elig_q  <= elig_d;
      out_q   <= out_d;
    end
  end

  always_comb begin
    beat_o     = out_q;
    beat_o.vld = out_vld_q;
  end

endmodule

[rtl/nearest_palette_quantizer_top.sv]
`timescale 1ns / 1ps
// Nearest-color palette quantizer, top level: input register, chain of
// palette cells and output register. Depends on npq_pkg, npq_in_if,
// npq_out_if and npq_cell.

// The block maps RGB888 pixels to the index of the nearest opaque palette
// entry. A beat with func 0 writes one palette entry (alpha zero marks it
// transparent); a beat with func 1 converts one pixel and yields exactly one
// result beat. Each pixel channel is cut to 5 bits and expanded back to 8
// before the search, which takes the squared Euclidean distance, keeps the
// lowest index on ties, skips entry 0 whenever more than one entry is in use,
// and answers 0 when nothing qualifies. Every palette entry lives in its own
// cell of a 256-cell chain, and each beat, write or pixel, walks that chain
// in order, so writes and pixels take effect exactly in arrival order. The
// chain takes one beat per clock cycle while the output is not stalled; a
// pixel passes the input register, the two register steps in every cell
// and the output register. A stalled output holds the whole chain. Entries
// must be written before a pixel can reach them; palette_count (reset 1,
// values above 256 act as 256) is set via cfg_we_i/cfg_wdata_i; the user
// must write it only while no beat is in flight, and the block does not enforce this.
module nearest_palette_quantizer_top
  import npq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  npq_in_if.sink          pixel_i,
  npq_out_if.source       result_o
);

  logic [CntW-1:0] count_q;
  logic            skip_first;
  logic            advance;
  beat_t           head_q, head_d;
  beat_t           link [MaxEntries+1];
  logic            out_vld_q;
  logic [IdxW-1:0] out_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign skip_first = count_q > CntW'(1);

  // The whole chain moves whenever the output register can take a result.
  assign advance       = !out_vld_q || result_o.ready;
  assign pixel_i.ready = advance;

  // Pixels are expanded here, once; palette writes pass their color as is.
  always_comb begin
    head_d           = '0;
    head_d.vld       = pixel_i.valid;
    head_d.func      = pixel_i.func;
    head_d.idx       = pixel_i.entry_index;
    head_d.opaque    = pixel_i.alpha != '0;
    head_d.best_dist = '1;
    head_d.best_idx  = '0;
    if (pixel_i.func == FuncConvert) begin
      head_d.red   = ExpandLut[pixel_i.red[ChanW-1 -: 5]];
      head_d.green = ExpandLut[pixel_i.green[ChanW-1 -: 5]];
      head_d.blue  = ExpandLut[pixel_i.blue[ChanW-1 -: 5]];
    end else begin
      head_d.red   = pixel_i.red;
      head_d.green = pixel_i.green;
      head_d.blue  = pixel_i.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (advance) begin
      head_q <= head_d;
    end
  end

  assign link[0] = head_q;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    npq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (advance),
      .cell_idx_i   (IdxW'(i)),
      .count_i      (count_q),
      .skip_first_i (skip_first),
      .beat_i       (link[i]),
      .beat_o       (link[i+1])
    );
  end

  // Write beats leave the chain here without a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= link[MaxEntries].vld && link[MaxEntries].func == FuncConvert;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_idx_q <= link[MaxEntries].best_idx;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.palette_index = out_idx_q;

endmodule
